// ===== rtl/bdasc_pkg.sv =====
// Shared types, constants and the power-of-ten table for the decimal text converter.
package bdasc_pkg;

	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned MAG_W      = 32;
	localparam int unsigned CHAR_W     = 8;

	localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(NUM_DIGITS - 1);
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SIGN = 3'b010,
		ST_RUN  = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic sub;
		logic advance;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic in_neg;
		logic ge;
		logic emit_needed;
		logic idx_last;
	} sts_t;

	function automatic logic [MAG_W-1:0] pow10(input logic [IDX_W-1:0] idx);
		logic [MAG_W-1:0] p;
		case (idx)
			4'd0:    p = 32'd1000000000;
			4'd1:    p = 32'd100000000;
			4'd2:    p = 32'd10000000;
			4'd3:    p = 32'd1000000;
			4'd4:    p = 32'd100000;
			4'd5:    p = 32'd10000;
			4'd6:    p = 32'd1000;
			4'd7:    p = 32'd100;
			4'd8:    p = 32'd10;
			default: p = 32'd1;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/bdasc_datapath.sv =====
// Datapath: magnitude, digit counter, power index and the output character register.
module bdasc_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [31:0]           signed_value,
	input  bdasc_pkg::cmd_t              cmd,
	output bdasc_pkg::sts_t              sts,
	output logic [bdasc_pkg::CHAR_W-1:0] text_char,
	output logic                         is_last
);
	import bdasc_pkg::*;

	logic [MAG_W-1:0]   mag_q;
	logic [DIGIT_W-1:0] digit_q;
	logic [IDX_W-1:0]   idx_q;
	logic               lead_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic [MAG_W-1:0]   pow;
	logic [MAG_W-1:0]   in_word;

	assign in_word = MAG_W'(signed_value);
	assign pow     = pow10(idx_q);

	assign sts.in_neg      = in_word[MAG_W-1];
	assign sts.ge          = (mag_q >= pow);
	assign sts.idx_last    = (idx_q == IDX_LAST);
	// The units digit always prints, which covers an input of zero
	assign sts.emit_needed = (digit_q != '0) || !lead_q || (idx_q == IDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			digit_q <= '0;
			lead_q  <= 1'b1;
		end else if (cmd.load) begin
			idx_q   <= '0;
			digit_q <= '0;
			lead_q  <= 1'b1;
		end else if (cmd.sub) begin
			digit_q <= digit_q + DIGIT_W'(1);
		end else if (cmd.advance) begin
			idx_q   <= idx_q + IDX_W'(1);
			digit_q <= '0;
			if (cmd.emit_digit) begin
				lead_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// Unsigned negate keeps the most negative value intact
			mag_q <= in_word[MAG_W-1] ? (~in_word + MAG_W'(1)) : in_word;
		end else if (cmd.sub) begin
			mag_q <= mag_q - pow;
		end
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CHAR_ZERO + CHAR_W'(digit_q);
			last_q <= (idx_q == IDX_LAST);
		end
	end

	assign text_char = char_q;
	assign is_last   = last_q;

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_q <= DIGIT_W'(9))
		else $error("digit count above nine");

	// The index steps one past the units digit on the final emission and rests there
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(NUM_DIGITS))
		else $error("power index out of range");

	a_sub_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sub |=> $past(mag_q) >= mag_q)
		else $error("subtraction wrapped the magnitude");

endmodule

// ===== rtl/bdasc_ctrl.sv =====
// Controller: sequences load, sign, digit subtraction and output register handshake.
module bdasc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  bdasc_pkg::sts_t sts,
	output bdasc_pkg::cmd_t cmd
);
	import bdasc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.in_neg ? ST_SIGN : ST_RUN;
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.ge) begin
					cmd.sub = 1'b1;
				end else if (!sts.emit_needed) begin
					// drop a leading zero
					cmd.advance = 1'b1;
				end else if (slot_free) begin
					cmd.advance    = 1'b1;
					cmd.emit_digit = 1'b1;
					if (sts.idx_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_sign || cmd.emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_emit_after_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_digit |-> !sts.ge)
		else $error("digit emitted before subtraction finished");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_digit && sts.idx_last) |=> (state_q == ST_IDLE))
		else $error("final digit did not return to idle");

	a_emit_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit) |=> out_valid_q)
		else $error("emitted character not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit) |-> slot_free)
		else $error("output register overwritten while held");

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// Signed 32-bit binary to decimal ASCII text converter, top level.
//
// Input channel: in_valid/in_ready carry one two's complement word on
// signed_value. Output channel: out_valid/out_ready carry one character
// per request on text_char, with is_last high on the final character.
// A negative value gives '-' first; leading zeros are dropped and zero
// prints as a single '0'. The most negative value prints in full.
// Each digit is found by repeated subtraction of a power of ten in a
// single shared compare-and-subtract unit. The controller steps through
// the load, a sign, the subtractions and one advance per digit position
// in that order; in_ready is high only while the controller is idle,
// one item at a time.
// A single output register decouples the sides: when the receiver stalls,
// the held character stays stable and the controller waits before the
// next emission, while subtractions for the pending digit carry on.
// Reset (arst_n low) returns the controller to idle and empties the
// output register.
module binary_to_decimal_ascii (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [31:0]           signed_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bdasc_pkg::CHAR_W-1:0] text_char,
	output logic                         is_last
);
	import bdasc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bdasc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bdasc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.signed_value (signed_value),
		.cmd          (cmd),
		.sts          (sts),
		.text_char    (text_char),
		.is_last      (is_last)
	);

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the signed binary to decimal ASCII text converter.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bdasc_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	class text_scoreboard;
		text_char_t expected_q[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		task report(input string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		// Expand one accepted word into the characters it must print.
		function void note_value(input logic [31:0] word);
			logic [31:0]       mag;
			logic [31:0]       pw;
			logic [31:0]       digit;
			logic [CHAR_W-1:0] text[$];
			bit                leading;
			text_char_t        item;
			if (word == 32'd0) begin
				text.push_back(CHAR_ZERO);
			end else begin
				leading = 1'b1;
				if (word[31]) begin
					text.push_back(CHAR_MINUS);
					mag = ~word + 32'd1;
				end else begin
					mag = word;
				end
				pw = 32'd1000000000;
				repeat (NUM_DIGITS) begin
					digit = mag / pw;
					mag   = mag % pw;
					if (digit != 32'd0 || !leading) begin
						text.push_back(CHAR_ZERO + CHAR_W'(digit));
						leading = 1'b0;
					end
					pw = pw / 32'd10;
				end
			end
			foreach (text[i]) begin
				item.ch   = text[i];
				item.last = (i == text.size() - 1);
				expected_q.push_back(item);
			end
		endfunction

		task check_char(input logic [CHAR_W-1:0] ch, input logic last);
			text_char_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected character 0x%02h last=%0b", ch, last));
				return;
			end
			want = expected_q.pop_front();
			if (ch !== want.ch)
				report($sformatf("text_char 0x%02h, expected 0x%02h", ch, want.ch));
			if (last !== want.last)
				report($sformatf("is_last %0b, expected %0b on 0x%02h", last, want.last, want.ch));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic signed [31:0]  signed_value = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [CHAR_W-1:0]   text_char;
	logic                is_last;

	text_scoreboard sb;
	int             src_idle_pct   = 0;
	int             sink_stall_pct = 0;
	bit             hold_request   = 1'b0;
	int             hold_left      = 0;

	int directed_values[20] = '{
		0, 1, -1, 9, 10, -10, 99, 100,
		2147483647, 32'h80000000, -2147483647,
		1000000000, 999999999, -999999999, 1000000001,
		1234567890, 32'h55555555, 32'hAAAAAAAA, 2000000000, 7
	};

	binary_to_decimal_ascii u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.signed_value (signed_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.text_char    (text_char),
		.is_last      (is_last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_value(input logic [31:0] v);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		in_valid     <= 1'b1;
		signed_value <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_value(v);
	endtask

	// Mostly pick a digit count first so short and long numbers both turn up.
	function automatic logic [31:0] random_value();
		longint      lo;
		longint      hi;
		int unsigned n;
		logic [31:0] mag;
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		n  = $urandom_range(1, 10);
		lo = 1;
		repeat (n - 1) lo = lo * 10;
		hi = lo * 10 - 1;
		if (hi > 2147483647)
			hi = 2147483647;
		case ($urandom_range(0, 7))
			0:       mag = 32'(lo);
			1:       mag = 32'(hi);
			default: mag = $urandom_range(32'(hi), 32'(lo));
		endcase
		if ($urandom_range(0, 1) == 1)
			return -mag;
		return mag;
	endfunction

	// Receiver: take characters and decide ready for the next edge.
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_char(text_char, is_last);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = 400;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_values[i])
			send_value(directed_values[i]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
				default: begin src_idle_pct = 18; sink_stall_pct = 18; end
			endcase
			// Hold the output off while requests keep coming, so the input stalls.
			if (phase == 2)
				hold_request = 1'b1;
			repeat (100) send_value(random_value());
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
